/* rtl/eidt_pkg.sv */
// Shared types and constants for the entity ID and component table.
package eidt_pkg;

    localparam int MAX_ENTITIES   = 256;
    localparam int NUM_COMPONENTS = 32;

    localparam int ID_W   = 9;
    localparam int COMP_W = 5;
    localparam int SLOT_W = $clog2(MAX_ENTITIES);

    typedef logic [ID_W-1:0]           t_id;
    typedef logic [SLOT_W-1:0]         t_slot;
    typedef logic [COMP_W-1:0]         t_comp;
    typedef logic [NUM_COMPONENTS-1:0] t_mask;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_REMOVE = 3'd1,
        OP_ATTACH = 3'd2,
        OP_DETACH = 3'd3,
        OP_QUERY  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_ENTITY = 2'd1,
        STS_BIT_STATE = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

/* rtl/entity_id_and_component_table.sv */
// Top level of the entity ID allocator with per-entity component masks.
//
// Issue a word by raising start while busy is low; it is taken at that clock
// edge. Each word is first captured while the mask and free stack memories
// are read (registered reads), then computed, written back and loaded into
// the result registers. busy is high while the word executes, and the result
// appears on the o_ ports for exactly one cycle with o_result_valid high, the
// same cycle in which the next word may be issued. No new word is taken
// while one executes. The receiver cannot stall: sample the result in the
// strobe cycle or lose it. Create reuses the most recently removed ID, else
// hands out the next fresh ID counting up from 1; once all IDs are out and
// the stack is empty it reports table full. Live bits are cleared by reset;
// mask and stack memories need no clearing since a mask is written by create
// before it is read and stack entries are read only below the stack depth.
// Every result carries the live count after the operation.
module entity_id_and_component_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [8:0]  i_entity_id,
    input  logic [4:0]  i_component_index,
    output logic        o_result_valid,
    output logic        o_ok,
    output logic [1:0]  o_status,
    output logic [8:0]  o_new_entity_id,
    output logic        o_component_present,
    output logic [31:0] o_component_mask,
    output logic [8:0]  o_live_count
);

    eidt_pkg::t_cmd cmd;

    // Sequence each word: capture, then execute and strobe.
    eidt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .o_cmd          (cmd),
        .o_result_valid (o_result_valid)
    );

    // Hold all table state and drive the result fields.
    eidt_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_opcode            (i_opcode),
        .i_entity_id         (i_entity_id),
        .i_component_index   (i_component_index),
        .o_ok                (o_ok),
        .o_status            (o_status),
        .o_new_entity_id     (o_new_entity_id),
        .o_component_present (o_component_present),
        .o_component_mask    (o_component_mask),
        .o_live_count        (o_live_count)
    );

endmodule

/* rtl/eidt_ctrl.sv */
// Controller: sequences one word through capture and execute.
module eidt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output eidt_pkg::t_cmd  o_cmd,
    output logic            o_result_valid
);

    eidt_pkg::t_state r_state, n_state;
    logic             r_strobe, n_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= eidt_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_strobe      = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        busy          = 1'b0;
        case (r_state)
            eidt_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = eidt_pkg::ST_EXEC;
                end
            end
            eidt_pkg::ST_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
                n_strobe   = 1'b1;
                n_state    = eidt_pkg::ST_IDLE;
            end
            default: begin
                n_state = eidt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_strobe;

endmodule

/* rtl/eidt_datapath.sv */
// Datapath: live bits, mask and free stack memories, counters, result registers.
module eidt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eidt_pkg::t_cmd       i_cmd,
    input  logic [2:0]           i_opcode,
    input  logic [8:0]           i_entity_id,
    input  logic [4:0]           i_component_index,
    output logic                 o_ok,
    output logic [1:0]           o_status,
    output logic [8:0]           o_new_entity_id,
    output logic                 o_component_present,
    output logic [31:0]          o_component_mask,
    output logic [8:0]           o_live_count
);

    localparam eidt_pkg::t_id MAX_ID = eidt_pkg::ID_W'(eidt_pkg::MAX_ENTITIES);

    // storage
    logic [eidt_pkg::MAX_ENTITIES-1:0] r_live;
    eidt_pkg::t_mask r_mask_mem  [eidt_pkg::MAX_ENTITIES];
    eidt_pkg::t_id   r_stack_mem [eidt_pkg::MAX_ENTITIES];

    // captured word and read data
    logic [2:0]        r_op;
    eidt_pkg::t_id     r_id;
    eidt_pkg::t_comp   r_comp;
    eidt_pkg::t_mask   r_mask_rdata;
    eidt_pkg::t_id     r_stack_rdata;

    // counters
    eidt_pkg::t_id r_depth, n_depth;
    eidt_pkg::t_id r_fresh, n_fresh;
    eidt_pkg::t_id r_total, n_total;

    // result registers
    logic             r_ok, n_ok;
    eidt_pkg::t_status r_status, n_status;
    eidt_pkg::t_id    r_new_id, n_new_id;
    logic             r_present, n_present;
    eidt_pkg::t_mask  r_mask_out, n_mask_out;

    // write controls
    logic            live_we, live_val;
    eidt_pkg::t_slot live_slot;
    logic            mask_we;
    eidt_pkg::t_slot mask_waddr;
    eidt_pkg::t_mask mask_wdata;
    logic            stack_we;

    // decode
    eidt_pkg::t_slot slot;
    logic            id_in_range, is_live, comp_ok, has_bit;
    eidt_pkg::t_mask sel_bit;
    eidt_pkg::t_id   cr_id;
    logic            cr_valid;

    assign slot        = eidt_pkg::SLOT_W'(r_id - 1'b1);
    assign id_in_range = (r_id != '0) && (r_id <= MAX_ID);
    assign is_live     = id_in_range && r_live[slot];
    assign comp_ok     = ({1'b0, r_comp} < (eidt_pkg::COMP_W + 1)'(eidt_pkg::NUM_COMPONENTS));
    assign sel_bit     = comp_ok ? (eidt_pkg::t_mask'(1) << r_comp) : '0;
    assign has_bit     = |(r_mask_rdata & sel_bit);

    // Capture the word and read both memories at the accept edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op          <= i_opcode;
            r_id          <= i_entity_id;
            r_comp        <= i_component_index;
            r_mask_rdata  <= r_mask_mem[eidt_pkg::SLOT_W'(i_entity_id - 1'b1)];
            r_stack_rdata <= r_stack_mem[eidt_pkg::SLOT_W'(r_depth - 1'b1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            r_mask_mem[mask_waddr] <= mask_wdata;
        end
        if (stack_we) begin
            r_stack_mem[eidt_pkg::SLOT_W'(r_depth)] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_depth <= '0;
            r_fresh <= '0;
            r_total <= '0;
        end else begin
            if (live_we) begin
                r_live[live_slot] <= live_val;
            end
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok       <= n_ok;
            r_status   <= n_status;
            r_new_id   <= n_new_id;
            r_present  <= n_present;
            r_mask_out <= n_mask_out;
        end
    end

    always_comb begin
        n_ok       = 1'b0;
        n_status   = eidt_pkg::STS_NO_ENTITY;
        n_new_id   = '0;
        n_present  = 1'b0;
        n_mask_out = '0;
        n_depth    = r_depth;
        n_fresh    = r_fresh;
        n_total    = r_total;
        live_we    = 1'b0;
        live_val   = 1'b0;
        live_slot  = slot;
        mask_we    = 1'b0;
        mask_waddr = slot;
        mask_wdata = '0;
        stack_we   = 1'b0;
        cr_id      = '0;
        cr_valid   = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                eidt_pkg::OP_CREATE: begin
                    if (r_depth != '0) begin
                        cr_id    = r_stack_rdata;
                        cr_valid = 1'b1;
                        n_depth  = r_depth - 1'b1;
                    end else if (r_fresh < MAX_ID) begin
                        n_fresh  = r_fresh + 1'b1;
                        cr_id    = n_fresh;
                        cr_valid = 1'b1;
                    end
                    if (cr_valid) begin
                        live_we    = 1'b1;
                        live_val   = 1'b1;
                        live_slot  = eidt_pkg::SLOT_W'(cr_id - 1'b1);
                        mask_we    = 1'b1;
                        mask_waddr = eidt_pkg::SLOT_W'(cr_id - 1'b1);
                        n_total    = r_total + 1'b1;
                        n_ok       = 1'b1;
                        n_status   = eidt_pkg::STS_OK;
                        n_new_id   = cr_id;
                    end else begin
                        n_status = eidt_pkg::STS_FULL;
                    end
                end
                eidt_pkg::OP_REMOVE: begin
                    if (is_live) begin
                        live_we = 1'b1;
                        if (r_depth < MAX_ID) begin
                            stack_we = 1'b1;
                            n_depth  = r_depth + 1'b1;
                        end
                        n_total  = r_total - 1'b1;
                        n_ok     = 1'b1;
                        n_status = eidt_pkg::STS_OK;
                    end
                end
                eidt_pkg::OP_ATTACH: begin
                    if (is_live) begin
                        if (!comp_ok || has_bit) begin
                            n_status   = eidt_pkg::STS_BIT_STATE;
                            n_present  = has_bit;
                            n_mask_out = r_mask_rdata;
                        end else begin
                            mask_we    = 1'b1;
                            mask_wdata = r_mask_rdata | sel_bit;
                            n_ok       = 1'b1;
                            n_status   = eidt_pkg::STS_OK;
                            n_present  = 1'b1;
                            n_mask_out = r_mask_rdata | sel_bit;
                        end
                    end
                end
                eidt_pkg::OP_DETACH: begin
                    if (is_live) begin
                        if (!comp_ok || !has_bit) begin
                            n_status   = eidt_pkg::STS_BIT_STATE;
                            n_mask_out = r_mask_rdata;
                        end else begin
                            mask_we    = 1'b1;
                            mask_wdata = r_mask_rdata & ~sel_bit;
                            n_ok       = 1'b1;
                            n_status   = eidt_pkg::STS_OK;
                            n_mask_out = r_mask_rdata & ~sel_bit;
                        end
                    end
                end
                eidt_pkg::OP_QUERY: begin
                    if (is_live) begin
                        n_ok       = 1'b1;
                        n_status   = eidt_pkg::STS_OK;
                        n_present  = has_bit;
                        n_mask_out = r_mask_rdata;
                    end
                end
                default: begin
                    n_status = eidt_pkg::STS_NO_ENTITY;
                end
            endcase
        end
    end

    assign o_ok                = r_ok;
    assign o_status            = r_status;
    assign o_new_entity_id     = r_new_id;
    assign o_component_present = r_present;
    assign o_component_mask    = r_mask_out;
    assign o_live_count        = r_total;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the entity ID allocator and component table.
`timescale 1ns / 100ps

module tb;

    // Local names for the package items the bench uses.
    typedef eidt_pkg::t_id     t_id;
    typedef eidt_pkg::t_comp   t_comp;
    typedef eidt_pkg::t_mask   t_mask;
    typedef eidt_pkg::t_status t_status;

    localparam int MAX_ENTITIES   = eidt_pkg::MAX_ENTITIES;
    localparam int NUM_COMPONENTS = eidt_pkg::NUM_COMPONENTS;

    localparam logic [2:0] OP_CREATE = eidt_pkg::OP_CREATE;
    localparam logic [2:0] OP_REMOVE = eidt_pkg::OP_REMOVE;
    localparam logic [2:0] OP_ATTACH = eidt_pkg::OP_ATTACH;
    localparam logic [2:0] OP_DETACH = eidt_pkg::OP_DETACH;
    localparam logic [2:0] OP_QUERY  = eidt_pkg::OP_QUERY;

    localparam t_status STS_OK        = eidt_pkg::STS_OK;
    localparam t_status STS_NO_ENTITY = eidt_pkg::STS_NO_ENTITY;
    localparam t_status STS_BIT_STATE = eidt_pkg::STS_BIT_STATE;
    localparam t_status STS_FULL      = eidt_pkg::STS_FULL;

    // Opcodes outside the defined set; the block must reject them.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int DRAIN_CYCLES = 8;

    // One result word as the block reports it.
    typedef struct packed {
        logic    ok;
        t_status status;
        t_id     new_id;
        logic    present;
        t_mask   mask;
        t_id     live;
    } t_table_result;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [2:0]    op;
        t_id           id;
        t_comp         comp;
        logic          typed;
        t_table_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [8:0]  i_entity_id;
    logic [4:0]  i_component_index;
    logic        o_result_valid;
    logic        o_ok;
    logic [1:0]  o_status;
    logic [8:0]  o_new_entity_id;
    logic        o_component_present;
    logic [31:0] o_component_mask;
    logic [8:0]  o_live_count;

    // Shadow copy of the table, advanced once per accepted word.
    bit    alive [MAX_ENTITIES];
    t_mask masks [MAX_ENTITIES];
    t_id   free_ids [MAX_ENTITIES];
    int    stk_depth;
    int    fresh_last;
    int    live_total;
    t_id   live_ids [$];

    t_table_result pending_results [$];
    t_row          dir_rows [$];

    int fail_count;
    int words_sent;
    int results_seen;
    int full_hits;
    int peak_live;
    int burst_left;

    always #4 i_clk = ~i_clk;

    entity_id_and_component_table u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_entity_id        (i_entity_id),
        .i_component_index  (i_component_index),
        .o_result_valid     (o_result_valid),
        .o_ok               (o_ok),
        .o_status           (o_status),
        .o_new_entity_id    (o_new_entity_id),
        .o_component_present(o_component_present),
        .o_component_mask   (o_component_mask),
        .o_live_count       (o_live_count)
    );

    // Apply one operation to the shadow table and return the result it gives.
    function automatic t_table_result predict_table_op(logic [2:0] op, t_id id, t_comp comp);
        t_table_result r;
        t_mask         bitv;
        t_mask         m;
        logic          comp_ok;
        logic          live_hit;
        int            slot;
        t_id           nid;
        r        = '0;
        comp_ok  = int'(comp) < NUM_COMPONENTS;
        bitv     = comp_ok ? (t_mask'(1) << comp) : '0;
        live_hit = 1'b0;
        if (id != '0 && int'(id) <= MAX_ENTITIES) begin
            live_hit = alive[int'(id) - 1];
        end
        if (op == OP_CREATE) begin
            nid = '0;
            if (stk_depth > 0) begin
                // Reuse the most recently freed ID first.
                stk_depth--;
                nid = free_ids[stk_depth];
            end else if (fresh_last < MAX_ENTITIES) begin
                fresh_last++;
                nid = t_id'(fresh_last);
            end
            if (nid == '0) begin
                r.status = STS_FULL;
                full_hits++;
            end else begin
                alive[int'(nid) - 1] = 1'b1;
                masks[int'(nid) - 1] = '0;
                live_total++;
                live_ids.push_back(nid);
                r.ok     = 1'b1;
                r.status = STS_OK;
                r.new_id = nid;
            end
        end else if (op > 3'(OP_QUERY) || !live_hit) begin
            r.status = STS_NO_ENTITY;
        end else begin
            slot = int'(id) - 1;
            m    = masks[slot];
            case (op)
                OP_REMOVE: begin
                    alive[slot] = 1'b0;
                    if (stk_depth < MAX_ENTITIES) begin
                        free_ids[stk_depth] = id;
                        stk_depth++;
                    end
                    live_total--;
                    foreach (live_ids[k]) begin
                        if (live_ids[k] == id) begin
                            live_ids.delete(k);
                            break;
                        end
                    end
                    r.ok = 1'b1;
                end
                OP_ATTACH: begin
                    if (!comp_ok || (m & bitv) != '0) begin
                        r.status  = STS_BIT_STATE;
                        r.present = (m & bitv) != '0;
                        r.mask    = m;
                    end else begin
                        m           = m | bitv;
                        masks[slot] = m;
                        r.ok        = 1'b1;
                        r.present   = 1'b1;
                        r.mask      = m;
                    end
                end
                OP_DETACH: begin
                    if (!comp_ok || (m & bitv) == '0) begin
                        r.status = STS_BIT_STATE;
                        r.mask   = m;
                    end else begin
                        m           = m & ~bitv;
                        masks[slot] = m;
                        r.ok        = 1'b1;
                        r.mask      = m;
                    end
                end
                default: begin
                    r.ok      = 1'b1;
                    r.present = (m & bitv) != '0;
                    r.mask    = m;
                end
            endcase
        end
        if (live_total > peak_live) begin
            peak_live = live_total;
        end
        r.live = t_id'(live_total);
        return r;
    endfunction

    function automatic t_row dir(logic [2:0] op, int id, int comp, bit typed, bit ok,
                                 t_status st, int nid, bit pres, logic [31:0] mask, int live);
        t_row rw;
        rw.op           = op;
        rw.id           = t_id'(id);
        rw.comp         = t_comp'(comp);
        rw.typed        = typed;
        rw.want.ok      = ok;
        rw.want.status  = st;
        rw.want.new_id  = t_id'(nid);
        rw.want.present = pres;
        rw.want.mask    = t_mask'(mask);
        rw.want.live    = t_id'(live);
        return rw;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Present one word, hold it until the block takes it, then log what it must produce.
    // Call at a rising edge; return at the edge that accepted the word.
    task automatic issue(logic [2:0] op, t_id id, t_comp comp, bit typed, t_table_result want);
        t_table_result got;
        i_opcode          <= op;
        i_entity_id       <= id;
        i_component_index <= comp;
        start             <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        got = predict_table_op(op, id, comp);
        pending_results.push_back(typed ? want : got);
        words_sent++;
    endtask

    // Burst pacing: count down the current burst, then drop start for a random gap.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop start and hold off until every logged result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Pick a target ID: mostly live ones, else a random in-range ID, zero, an out-of-range ID or the top ID.
    function automatic t_id pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && live_ids.size() > 0) begin
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        end else if (r < 82) begin
            return t_id'($urandom_range(1, MAX_ENTITIES));
        end else if (r < 87) begin
            return '0;
        end else if (r < 94) begin
            return t_id'($urandom_range(MAX_ENTITIES + 1, 511));
        end
        return t_id'(MAX_ENTITIES);
    endfunction

    task automatic send_random(int w_create, int w_remove);
        int         r;
        logic [2:0] op;
        t_id        id;
        t_comp      comp;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        end else if (r < 3 + w_create) begin
            op = OP_CREATE;
        end else if (r < 3 + w_create + w_remove) begin
            op = OP_REMOVE;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = OP_ATTACH;
                1:       op = OP_DETACH;
                default: op = OP_QUERY;
            endcase
        end
        // Crowd half the indexes onto a few bits so attach and detach collide.
        id   = pick_target();
        comp = ($urandom_range(0, 1) == 0) ? t_comp'($urandom_range(0, 31))
                                           : t_comp'($urandom_range(0, 3));
        issue(op, id, comp, 1'b0, '0);
        pace();
    endtask

    // Score every result strobe against the oldest logged expectation.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with no expectation pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("ok",                32'(want.ok),      32'(o_ok));
                compare_field("status",            32'(want.status),  32'(o_status));
                compare_field("new_entity_id",     32'(want.new_id),  32'(o_new_entity_id));
                compare_field("component_present", 32'(want.present), 32'(o_component_present));
                compare_field("component_mask",    32'(want.mask),    o_component_mask);
                compare_field("live_count",        32'(want.live),    32'(o_live_count));
            end
        end
    end

    initial begin
        t_row rw;
        start             <= 1'b0;
        i_rst_n           <= 1'b0;
        i_opcode          <= OP_QUERY;
        i_entity_id       <= '0;
        i_component_index <= '0;
        stk_depth    = 0;
        fresh_last   = 0;
        live_total   = 0;
        fail_count   = 0;
        words_sent   = 0;
        results_seen = 0;
        full_hits    = 0;
        peak_live    = 0;
        burst_left   = 4;
        foreach (alive[k]) alive[k] = 1'b0;

        // Directed table: typed expectations where the answer is plain, else predicted.
        dir_rows.push_back(dir(OP_QUERY,  1,   0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 0));
        dir_rows.push_back(dir(OP_CREATE, 0,   0,  1, 1, STS_OK,        1, 0, 0, 1));
        dir_rows.push_back(dir(OP_CREATE, 0,   0,  1, 1, STS_OK,        2, 0, 0, 2));
        dir_rows.push_back(dir(OP_ATTACH, 1,   31, 1, 1, STS_OK,        0, 1, 32'h8000_0000, 2));
        dir_rows.push_back(dir(OP_ATTACH, 1,   31, 1, 0, STS_BIT_STATE, 0, 1, 32'h8000_0000, 2));
        dir_rows.push_back(dir(OP_DETACH, 1,   0,  1, 0, STS_BIT_STATE, 0, 0, 32'h8000_0000, 2));
        dir_rows.push_back(dir(OP_ATTACH, 1,   0,  1, 1, STS_OK,        0, 1, 32'h8000_0001, 2));
        dir_rows.push_back(dir(OP_QUERY,  1,   31, 1, 1, STS_OK,        0, 1, 32'h8000_0001, 2));
        dir_rows.push_back(dir(OP_QUERY,  1,   15, 1, 1, STS_OK,        0, 0, 32'h8000_0001, 2));
        dir_rows.push_back(dir(OP_DETACH, 1,   31, 1, 1, STS_OK,        0, 0, 32'h0000_0001, 2));
        dir_rows.push_back(dir(OP_QUERY,  0,   0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_QUERY,  256, 0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_ATTACH, 511, 31, 1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_RSVD5,  1,   0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_RSVD6,  2,   31, 1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_RSVD7,  511, 31, 1, 0, STS_NO_ENTITY, 0, 0, 0, 2));
        dir_rows.push_back(dir(OP_REMOVE, 1,   0,  1, 1, STS_OK,        0, 0, 0, 1));
        dir_rows.push_back(dir(OP_REMOVE, 1,   0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 1));
        dir_rows.push_back(dir(OP_QUERY,  1,   0,  1, 0, STS_NO_ENTITY, 0, 0, 0, 1));
        dir_rows.push_back(dir(OP_REMOVE, 2,   0,  1, 1, STS_OK,        0, 0, 0, 0));
        // Free stack is LIFO: 2 comes back before 1, and a reused mask is clear.
        dir_rows.push_back(dir(OP_CREATE, 0,   0,  1, 1, STS_OK,        2, 0, 0, 1));
        dir_rows.push_back(dir(OP_CREATE, 0,   0,  1, 1, STS_OK,        1, 0, 0, 2));
        dir_rows.push_back(dir(OP_QUERY,  1,   0,  1, 1, STS_OK,        0, 0, 0, 2));
        dir_rows.push_back(dir(OP_CREATE, 0,   0,  0, 0, STS_OK,        0, 0, 0, 0));
        dir_rows.push_back(dir(OP_ATTACH, 3,   16, 0, 0, STS_OK,        0, 0, 0, 0));

        // Hold reset, then release it for good.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            rw = dir_rows[k];
            issue(rw.op, rw.id, rw.comp, rw.typed, rw.want);
            pace();
        end
        wait_drained();

        // Grow the table: creates dominate.
        repeat (300) send_random(40, 10);
        wait_drained();

        // Fill every ID, then keep asking so the table-full case fires.
        while (!(fresh_last >= MAX_ENTITIES && stk_depth == 0)) begin
            if ($urandom_range(0, 2) == 0 && live_ids.size() > 0) begin
                issue(OP_ATTACH, live_ids[$urandom_range(0, live_ids.size() - 1)],
                      t_comp'($urandom_range(0, 31)), 1'b0, '0);
            end else begin
                issue(OP_CREATE, t_id'($urandom_range(0, 511)), t_comp'($urandom_range(0, 31)),
                      1'b0, '0);
            end
            pace();
        end
        repeat (5) begin
            issue(OP_CREATE, '0, '0, 1'b0, '0);
            pace();
        end
        repeat (20) send_random(10, 5);
        wait_drained();

        // Shrink the table hard, refilling from the free stack now and then.
        repeat (250) send_random(10, 45);

        // Balanced churn to finish.
        repeat (110) send_random(25, 25);

        // Drain, then idle out the pipeline before judging the run.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d words sent, %0d results checked, %0d mismatches",
                 words_sent, results_seen, fail_count);
        $display("tb: peak live count %0d, table-full rejections %0d", peak_live, full_hits);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run ends well inside this.
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
